>>> src/pss_pkg.sv
// Shared constants, codes, handshake structs and helper functions for the
// pattern step sequencer. No dependencies.
package pss_pkg;

  // Sizing of the sequencer.
  localparam int NOTE_BITS  = 12;
  localparam int STEPS      = 16;
  localparam int PATTERNS   = 8;
  localparam int CHANNELS   = 4;
  localparam int DIVIDE_MAX = 16;
  localparam int REPEAT_MAX = 16;
  localparam int unsigned CV_PER_NOTE = 300;

  // Port widths fixed by the interface.
  localparam int CMD_W     = 2;
  localparam int WPAT_W    = 3;
  localparam int WSTEP_W   = 4;
  localparam int MASK_W    = 12;
  localparam int GATE_W    = 4;
  localparam int CV_W      = 12;
  localparam int CURSOR_W  = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_CH    = 4;

  // Derived internal widths.
  localparam int DEPTH     = PATTERNS * STEPS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int POS_W     = $clog2(STEPS + 1);
  localparam int TICK_W    = $clog2(DIVIDE_MAX + 1);
  localparam int REP_W     = $clog2(REPEAT_MAX);
  localparam int REP_CNT_W = REP_W + 1;
  localparam int CNT_W     = $clog2(NOTE_BITS + 1);
  localparam int NIDX_W    = $clog2(NOTE_BITS);
  localparam int RANK_W    = (REP_W > CNT_W) ? REP_W : CNT_W;

  localparam logic [GATE_W-1:0] ALL_GATES = GATE_W'((1 << CHANNELS) - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PLAY_ARPEGGIO   = 2'd0,
    PLAY_CHORD      = 2'd1,
    PLAY_PERCUSSION = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAY_MODE      = 3'd0,
    CFG_CLOCK_DIVIDE   = 3'd1,
    CFG_PATTERN_SELECT = 3'd2,
    CFG_STEP_COUNT     = 3'd3,
    CFG_ARP_REPEATS    = 3'd4
  } cfg_idx_t;

  // Request to the note scan unit.
  typedef struct packed {
    logic                 start;
    logic [NOTE_BITS-1:0] word;
    logic [RANK_W-1:0]    rank;
    logic [CNT_W-1:0]     modulus;
  } scan_req_t;

  // Status of the note scan unit; fields are valid from done onward.
  typedef struct packed {
    logic                             done;
    logic [CNT_W-1:0]                 total;
    logic                             hit;
    logic [NIDX_W-1:0]                pick;
    logic [CHANNELS-1:0][NIDX_W-1:0]  chan;
  } scan_res_t;

  // DAC code of a note.
  function automatic logic [CV_W-1:0] cv_code(input logic [NIDX_W-1:0] note);
    return CV_W'(32'(note) * CV_PER_NOTE);
  endfunction

  // Effective clock divide, 1..DIVIDE_MAX.
  function automatic logic [TICK_W-1:0] div_len(input logic [CFG_W-1:0] v);
    if (v == '0) return TICK_W'(1);
    if (int'(v) > DIVIDE_MAX) return TICK_W'(DIVIDE_MAX);
    return TICK_W'(v);
  endfunction

  // Effective pattern length, 1..STEPS.
  function automatic logic [POS_W-1:0] step_len(input logic [CFG_W-1:0] v);
    if (v == '0) return POS_W'(1);
    if (int'(v) > STEPS) return POS_W'(STEPS);
    return POS_W'(v);
  endfunction

  // Effective arpeggio repeats, 1..REPEAT_MAX.
  function automatic logic [REP_CNT_W-1:0] rep_len(input logic [CFG_W-1:0] v);
    if (v == '0) return REP_CNT_W'(1);
    if (int'(v) > REPEAT_MAX) return REP_CNT_W'(REPEAT_MAX);
    return REP_CNT_W'(v);
  endfunction

endpackage

>>> src/pss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/pss_scan.sv
// Note scan unit: reduces a rank modulo a note count, then walks a note
// word one bit per cycle. Depends on pss_pkg.
module pss_scan (
  input  logic               clk,
  input  logic               rst,
  input  pss_pkg::scan_req_t req,
  output pss_pkg::scan_res_t res
);
  import pss_pkg::*;

  typedef enum logic [1:0] {
    P_IDLE,
    P_REDUCE,
    P_WALK
  } phase_t;

  phase_t                          phase;
  logic [NOTE_BITS-1:0]            word;
  logic [RANK_W-1:0]               rank;
  logic [CNT_W-1:0]                modulus;
  logic [NIDX_W-1:0]               bit_idx;
  logic [CNT_W-1:0]                seen;
  logic                            hit;
  logic [NIDX_W-1:0]               pick;
  logic [CHANNELS-1:0][NIDX_W-1:0] chan;
  logic                            done;

  // Sequence the reduce and walk phases
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (req.start) begin
            word    <= req.word;
            rank    <= req.rank;
            modulus <= req.modulus;
            bit_idx <= '0;
            seen    <= '0;
            hit     <= 1'b0;
            phase   <= P_REDUCE;
          end
        end
        P_REDUCE: begin
          // subtract the note count until the rank falls below it
          if (modulus != '0 && rank >= RANK_W'(modulus)) begin
            rank <= rank - RANK_W'(modulus);
          end else begin
            phase <= P_WALK;
          end
        end
        P_WALK: begin
          if (word[bit_idx]) begin
            if (RANK_W'(seen) == rank) begin
              hit  <= 1'b1;
              pick <= bit_idx;
            end
            for (int k = 0; k < CHANNELS; k++) begin
              if (int'(seen) == k) begin
                chan[k] <= bit_idx;
              end
            end
            seen <= seen + CNT_W'(1);
          end
          if (int'(bit_idx) == NOTE_BITS - 1) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end else begin
            bit_idx <= bit_idx + NIDX_W'(1);
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign res.done  = done;
  assign res.total = seen;
  assign res.hit   = hit;
  assign res.pick  = pick;
  assign res.chan  = chan;

endmodule

>>> src/pattern_step_sequencer_unit.sv
// Pattern step sequencer top level: command decode, tick divider, play
// state, pattern RAM and result register. Depends on pss_pkg, pss_ram, pss_scan.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      cmd, write_pattern, write_step, note_mask
//  result    out        result_valid / result_ready  gate_pulse, cv_one..cv_four, cursor
//  config    in         cfg_we (no wait)             cfg_index, cfg_data
//
// Reset, write and non-firing tick items are handled on acceptance. A fired
// drum step passes through accept, RAM read, load and output. Poly steps and
// arpeggio steps that move to a new pattern step add the note scan, which
// walks the 12 note bits one per cycle. Other arpeggio sub-steps scan the held
// list after up to 15 rank-reduction subtractions, or skip it when it is empty.
// Reset is synchronous and clears the play state, the held CVs and the
// per-entry valid bits of the pattern RAM at once. A stalled result holds in
// the output register while the next item is accepted; a second fired step
// waits in its output state until the register frees.
module pattern_step_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [pss_pkg::CMD_W-1:0]      cmd,
  input  logic [pss_pkg::WPAT_W-1:0]     write_pattern,
  input  logic [pss_pkg::WSTEP_W-1:0]    write_step,
  input  logic [pss_pkg::MASK_W-1:0]     note_mask,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [pss_pkg::GATE_W-1:0]     gate_pulse,
  output logic [pss_pkg::CV_W-1:0]       cv_one,
  output logic [pss_pkg::CV_W-1:0]       cv_two,
  output logic [pss_pkg::CV_W-1:0]       cv_three,
  output logic [pss_pkg::CV_W-1:0]       cv_four,
  output logic [pss_pkg::CURSOR_W-1:0]   cursor,
  input  logic                           cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pss_pkg::CFG_W-1:0]      cfg_data
);
  import pss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_SCAN,
    S_OUT
  } state_t;

  state_t                  state;
  logic [1:0]              play_mode;
  logic [CFG_W-1:0]        clock_divide;
  logic [2:0]              pattern_select;
  logic [CFG_W-1:0]        step_count;
  logic [CFG_W-1:0]        arp_repeats;

  logic [POS_W-1:0]        position;
  logic [TICK_W-1:0]       tick_count;
  logic [REP_W-1:0]        sub_position;
  logic [NOTE_BITS-1:0]    sub_word;
  logic [CNT_W-1:0]        sub_total;
  logic [CV_W-1:0]         cv_hold [OUT_CH];
  logic [GATE_W-1:0]       gates;
  logic                    rebuild;
  logic [DEPTH-1:0]        row_valid;
  logic                    rd_vld;

  logic                    accept;
  logic                    fire;
  logic                    wrap;
  logic [POS_W-1:0]        length;
  logic [REP_CNT_W-1:0]    repeats;
  logic [REP_CNT_W-1:0]    sub_inc;
  logic [POS_W:0]          pos_inc;
  logic [POS_W-1:0]        pos_adv;
  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;
  logic [NOTE_BITS-1:0]    rdata;
  logic [NOTE_BITS-1:0]    load_word;
  logic [GATE_W-1:0]       poly_gates;
  logic                    wr_in_range;
  scan_req_t               scan_req;
  scan_res_t               scan_res;

  // Decode the item and the effective register values
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign length     = step_len(step_count);
  assign repeats    = rep_len(arp_repeats);
  assign fire       = accept && (cmd == CMD_TICK) && (tick_count <= TICK_W'(1));
  assign sub_inc    = {1'b0, sub_position} + REP_CNT_W'(1);
  assign wrap       = (sub_inc >= repeats);
  assign pos_inc    = {1'b0, position} + (POS_W + 1)'(1);
  assign pos_adv    = (pos_inc >= {1'b0, length}) ? '0 : pos_inc[POS_W-1:0];
  assign load_word  = rd_vld ? rdata : '0;

  // Form RAM addresses: write from the item, read from the play position
  always_comb begin
    int pat_i;
    int pos_i;
    wr_in_range = (int'(write_pattern) < PATTERNS) && (int'(write_step) < STEPS);
    waddr = ADDR_W'(int'(write_pattern) * STEPS + int'(write_step));
    pat_i = (int'(pattern_select) >= PATTERNS) ? PATTERNS - 1 : int'(pattern_select);
    pos_i = (int'(position) >= STEPS) ? STEPS - 1 : int'(position);
    raddr = ADDR_W'(pat_i * STEPS + pos_i);
  end

  // Writes happen only on accept in idle, reads only in the read state
  assign ram_we = accept && (cmd == CMD_WRITE) && wr_in_range;
  assign ram_re = (state == S_READ);

  pss_ram #(
    .WIDTH (NOTE_BITS),
    .DEPTH (DEPTH)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (NOTE_BITS'(note_mask)),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Start a scan: held note list on a plain sub-step, fresh word after a load
  always_comb begin
    scan_req.start   = 1'b0;
    scan_req.word    = sub_word;
    scan_req.rank    = RANK_W'(sub_inc);
    scan_req.modulus = sub_total;
    if (state == S_LOAD) begin
      scan_req.start   = (play_mode != PLAY_PERCUSSION);
      scan_req.word    = load_word;
      scan_req.rank    = '0;
      scan_req.modulus = '0;
    end else if (fire && play_mode == PLAY_ARPEGGIO && !wrap && sub_total != '0) begin
      scan_req.start = 1'b1;
    end
  end

  pss_scan u_scan (
    .clk (clk),
    .rst (rst),
    .req (scan_req),
    .res (scan_res)
  );

  // Gate the first set notes onto the poly channels
  always_comb begin
    poly_gates = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      poly_gates[k] = (int'(scan_res.total) > k);
    end
  end

  // Sequencer state, configuration, play state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      play_mode      <= PLAY_ARPEGGIO;
      clock_divide   <= CFG_W'(1);
      pattern_select <= '0;
      step_count     <= CFG_W'(16);
      arp_repeats    <= CFG_W'(1);
      position       <= '0;
      tick_count     <= TICK_W'(1);
      sub_position   <= '0;
      sub_total      <= '0;
      row_valid      <= '0;
      result_valid   <= 1'b0;
      for (int c = 0; c < OUT_CH; c++) begin
        cv_hold[c] <= '0;
      end
    end else begin
      // take configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLAY_MODE:      play_mode      <= cfg_data[1:0];
          CFG_CLOCK_DIVIDE:   clock_divide   <= cfg_data;
          CFG_PATTERN_SELECT: pattern_select <= cfg_data[2:0];
          CFG_STEP_COUNT:     step_count     <= cfg_data;
          CFG_ARP_REPEATS:    arp_repeats    <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once taken, unless the next one loads this cycle
      if (result_valid && result_ready && state != S_OUT) begin
        result_valid <= 1'b0;
      end

      if (ram_we) begin
        row_valid[waddr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_RESET: begin
                position   <= length;
                tick_count <= TICK_W'(1);
              end
              CMD_TICK: begin
                if (!fire) begin
                  tick_count <= tick_count - TICK_W'(1);
                end else begin
                  tick_count <= div_len(clock_divide);
                  case (play_mode)
                    PLAY_ARPEGGIO: begin
                      if (wrap) begin
                        sub_position <= '0;
                        position     <= pos_adv;
                        rebuild      <= 1'b1;
                        state        <= S_READ;
                      end else begin
                        sub_position <= sub_inc[REP_W-1:0];
                        rebuild      <= 1'b0;
                        if (sub_total == '0) begin
                          gates <= '0;
                          state <= S_OUT;
                        end else begin
                          state <= S_SCAN;
                        end
                      end
                    end
                    PLAY_CHORD, PLAY_PERCUSSION: begin
                      // leave the arpeggio note list alone
                      position <= pos_adv;
                      rebuild  <= 1'b0;
                      state    <= S_READ;
                    end
                    default: ;
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          rd_vld <= row_valid[raddr];
          state  <= S_LOAD;
        end
        S_LOAD: begin
          if (play_mode == PLAY_PERCUSSION) begin
            gates <= GATE_W'(load_word[CHANNELS-1:0]);
            state <= S_OUT;
          end else begin
            if (rebuild) begin
              sub_word <= load_word;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (play_mode == PLAY_ARPEGGIO) begin
              sub_total <= scan_res.total;
              if (scan_res.total != '0) begin
                for (int c = 0; c < CHANNELS; c++) begin
                  cv_hold[c] <= cv_code(scan_res.pick);
                end
                gates <= ALL_GATES;
              end else begin
                gates <= '0;
              end
            end else begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (int'(scan_res.total) > c) begin
                  cv_hold[c] <= cv_code(scan_res.chan[c]);
                end
              end
              gates <= poly_gates;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            gate_pulse   <= gates;
            cv_one       <= cv_hold[0];
            cv_two       <= cv_hold[1];
            cv_three     <= cv_hold[2];
            cv_four      <= cv_hold[3];
            cursor       <= CURSOR_W'(position);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The RAM never sees a write and a read in the same cycle
  a_ram_single_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("pattern RAM written and read in one cycle");

  // Scan completions arrive only while the sequencer waits for them
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> (state == S_SCAN))
    else $error("scan finished outside the scan state");

  // An arpeggio scan finds its note exactly when the list is non-empty
  a_arp_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_res.done && play_mode == PLAY_ARPEGGIO)
      |-> (scan_res.hit == (scan_res.total != '0)))
    else $error("arpeggio note not found in non-empty list");

  // The sub-step stays below the repeat count while a step is in work
  a_sub_position: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && play_mode == PLAY_ARPEGGIO) |-> ({1'b0, sub_position} < repeats))
    else $error("sub-step position beyond repeat count");

  // The held note count never exceeds the note word width
  a_sub_total: assert property (@(posedge clk) disable iff (rst)
    int'(sub_total) <= NOTE_BITS)
    else $error("note count out of range");

endmodule

>>> tb/pattern_step_sequencer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for pattern_step_sequencer_unit: drives command items and
// register settings, predicts every fired step and checks the results. Depends on
// pss_pkg and the sequencer RTL.
module pattern_step_sequencer_unit_test;
  import pss_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_SPARE     = 2'd3;
  localparam logic [1:0]           PLAY_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [WPAT_W-1:0]  pat;
    logic [WSTEP_W-1:0] step;
    logic [MASK_W-1:0]  mask;
  } seq_item_t;

  typedef struct packed {
    logic [GATE_W-1:0]            gates;
    logic [OUT_CH-1:0][CV_W-1:0]  cv;
    logic [CURSOR_W-1:0]          cursor;
  } step_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic [CMD_W-1:0]     cmd = '0;
  logic [WPAT_W-1:0]    write_pattern = '0;
  logic [WSTEP_W-1:0]   write_step = '0;
  logic [MASK_W-1:0]    note_mask = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [GATE_W-1:0]    gate_pulse;
  logic [CV_W-1:0]      cv_one, cv_two, cv_three, cv_four;
  logic [CURSOR_W-1:0]  cursor;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pattern_step_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .cmd(cmd), .write_pattern(write_pattern), .write_step(write_step),
    .note_mask(note_mask),
    .result_valid(result_valid), .result_ready(result_ready),
    .gate_pulse(gate_pulse), .cv_one(cv_one), .cv_two(cv_two),
    .cv_three(cv_three), .cv_four(cv_four), .cursor(cursor),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted sequencer state and register copies
  logic [MASK_W-1:0]    pat_mem [DEPTH];
  int unsigned          play_pos, tick_left, sub_pos, sub_cnt;
  int unsigned          sub_list [NOTE_BITS];
  logic [CV_W-1:0]      cv_held [OUT_CH];
  logic [1:0]           mode_reg;
  logic [CFG_W-1:0]     div_reg, len_reg, rep_reg;
  logic [WPAT_W-1:0]    sel_reg;

  seq_item_t   pending_items [$];
  step_out_t   expected_steps [$];
  int unsigned items_pushed, items_taken, results_checked, mismatches;
  int unsigned cfg_writes, phases;
  bit          in_fire;
  logic        next_valid;
  int unsigned burst_left = 1, gap_left = 0;
  int unsigned stall_cycle = 0, stall_style = 0;
  logic [15:0] stall_bits = 16'hffff;

  initial forever #5 clk = ~clk;

  initial begin
    #8ms;
    $display("Timeout: sequencer stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned bounded(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Word of the selected pattern at the play position
  function automatic logic [MASK_W-1:0] word_at_pos();
    int unsigned p;
    p = (play_pos >= STEPS) ? STEPS - 1 : play_pos;
    return pat_mem[int'(sel_reg) * STEPS + p];
  endfunction

  task automatic advance_pos();
    play_pos++;
    if (play_pos >= bounded(len_reg, STEPS)) play_pos = 0;
  endtask

  // Work out the result, if any, of one accepted item
  task automatic predict_step_output(input seq_item_t it);
    logic [MASK_W-1:0] w;
    logic [GATE_W-1:0] gates;
    int unsigned       k, note;
    bit                fired;
    step_out_t         r;
    gates = '0;
    fired = 1'b0;
    case (it.cmd)
      CMD_RESET: begin
        play_pos = bounded(len_reg, STEPS);
        tick_left = 1;
      end
      CMD_WRITE: pat_mem[{it.pat, it.step}] = it.mask;
      CMD_TICK: begin
        if (tick_left <= 1) begin
          tick_left = bounded(div_reg, DIVIDE_MAX);
          fired = 1'b1;
        end else begin
          tick_left--;
        end
      end
      default: ;
    endcase
    if (!fired) return;
    case (mode_reg)
      PLAY_ARPEGGIO: begin
        sub_pos++;
        if (sub_pos >= bounded(rep_reg, REPEAT_MAX)) begin
          sub_pos = 0;
          advance_pos();
          w = word_at_pos();
          sub_cnt = 0;
          for (int i = 0; i < NOTE_BITS; i++) begin
            if (w[i]) begin
              sub_list[sub_cnt] = i;
              sub_cnt++;
            end
          end
        end
        if (sub_cnt != 0) begin
          note = sub_list[sub_pos % sub_cnt];
          for (int c = 0; c < CHANNELS; c++) cv_held[c] = CV_W'(note * CV_PER_NOTE);
          gates = GATE_W'((1 << CHANNELS) - 1);
        end
      end
      PLAY_CHORD: begin
        advance_pos();
        w = word_at_pos();
        k = 0;
        for (int i = 0; i < NOTE_BITS; i++) begin
          if (w[i] && k < CHANNELS) begin
            gates[k] = 1'b1;
            cv_held[k] = CV_W'(i * CV_PER_NOTE);
            k++;
          end
        end
      end
      PLAY_PERCUSSION: begin
        advance_pos();
        gates = GATE_W'(word_at_pos()) & GATE_W'((1 << CHANNELS) - 1);
      end
      default: return;
    endcase
    r.gates = gates;
    for (int c = 0; c < OUT_CH; c++) r.cv[c] = cv_held[c];
    r.cursor = play_pos[CURSOR_W-1:0];
    expected_steps.push_back(r);
  endtask

  // Take accepted items into the prediction and check accepted results
  always @(posedge clk) begin
    step_out_t got, want;
    in_fire = !rst && item_valid && item_ready;
    if (!rst && result_valid && result_ready) begin
      got.gates = gate_pulse;
      got.cv[0] = cv_one;
      got.cv[1] = cv_two;
      got.cv[2] = cv_three;
      got.cv[3] = cv_four;
      got.cursor = cursor;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing expected: gate %h cv %h %h %h %h cursor %0d",
                   $time, got.gates, got.cv[0], got.cv[1], got.cv[2], got.cv[3], got.cursor);
      end else begin
        want = expected_steps.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: step mismatch", $time);
            $display("  expected gate %h cv %h %h %h %h cursor %0d",
                     want.gates, want.cv[0], want.cv[1], want.cv[2], want.cv[3], want.cursor);
            $display("  actual   gate %h cv %h %h %h %h cursor %0d",
                     got.gates, got.cv[0], got.cv[1], got.cv[2], got.cv[3], got.cursor);
          end
        end
      end
    end
    if (in_fire) begin
      predict_step_output('{cmd, write_pattern, write_step, note_mask});
      items_taken++;
    end
  end

  // Feed pending items in bursts separated by random gaps
  always @(negedge clk) begin
    next_valid = item_valid && !in_fire;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        {cmd, write_pattern, write_step, note_mask} <= pending_items.pop_front();
        next_valid = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end
      end
    end
    item_valid <= next_valid;
  end

  // Receiver stall pattern, switching at regular intervals among four styles
  always @(negedge clk) begin
    stall_cycle++;
    if (stall_cycle % 128 == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_bits = 16'($urandom);
    end
    case (stall_style)
      0: result_ready <= 1'b1;
      1: result_ready <= 1'($urandom);
      2: result_ready <= stall_bits[stall_cycle % 16];
      default: result_ready <= (stall_cycle % 24 == 0);
    endcase
  end

  task automatic push_item(input logic [CMD_W-1:0] c, input logic [WPAT_W-1:0] p,
                           input logic [WSTEP_W-1:0] s, input logic [MASK_W-1:0] m);
    pending_items.push_back('{c, p, s, m});
    items_pushed++;
  endtask

  // Tick, reset or spare item with random payload
  task automatic push_bare(input logic [CMD_W-1:0] c);
    push_item(c, WPAT_W'($urandom), WSTEP_W'($urandom), MASK_W'($urandom));
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return MASK_W'(1) << $urandom_range(0, NOTE_BITS - 1);
      3: return MASK_W'($urandom & $urandom);
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // Mostly in the usual range, sometimes zero or above the top
  function automatic logic [CFG_W-1:0] pick_cfg(input int unsigned common_hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'($urandom_range(16, 31));
      default: return CFG_W'($urandom_range(1, common_hi));
    endcase
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_writes++;
    case (idx)
      CFG_PLAY_MODE:      mode_reg = val[1:0];
      CFG_CLOCK_DIVIDE:   div_reg = val;
      CFG_PATTERN_SELECT: sel_reg = val[WPAT_W-1:0];
      CFG_STEP_COUNT:     len_reg = val;
      CFG_ARP_REPEATS:    rep_reg = val;
      default: ;
    endcase
  endtask

  // Write all registers while idle, optionally poking an unused index too
  task automatic apply_settings(input logic [1:0] m, input logic [CFG_W-1:0] d,
                                input logic [WPAT_W-1:0] s, input logic [CFG_W-1:0] l,
                                input logic [CFG_W-1:0] r, input bit poke_spare);
    set_reg(CFG_PLAY_MODE, CFG_W'(m));
    set_reg(CFG_CLOCK_DIVIDE, d);
    set_reg(CFG_PATTERN_SELECT, CFG_W'(s));
    set_reg(CFG_STEP_COUNT, l);
    set_reg(CFG_ARP_REPEATS, r);
    if (poke_spare) set_reg(CFG_SPARE_IDX, CFG_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // Hold until every item is taken and every result has come, then settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((items_taken != items_pushed || expected_steps.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_steps.size() != 0) begin
      mismatches += expected_steps.size();
      $display("%0t: %0d expected steps never arrived", $time, expected_steps.size());
      expected_steps.delete();
    end
  endtask

  // Random phase: new settings, fill the pattern, usually restart, then mostly ticks
  task automatic run_random_phase();
    int unsigned pick, count;
    apply_settings(($urandom_range(0, 11) == 0) ? PLAY_SPARE : 2'($urandom_range(0, 2)),
                   pick_cfg(4), WPAT_W'($urandom_range(0, 7)), pick_cfg(STEPS),
                   pick_cfg(5), $urandom_range(0, 5) == 0);
    count = $urandom_range(30, 70);
    repeat ($urandom_range(2, 8))
      push_item(CMD_WRITE, sel_reg, WSTEP_W'($urandom), pick_mask());
    if ($urandom_range(0, 4) != 0) push_bare(CMD_RESET);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) push_bare(CMD_TICK);
      else if (pick < 85)
        push_item(CMD_WRITE, ($urandom_range(0, 1) != 0) ? sel_reg : WPAT_W'($urandom),
                  WSTEP_W'($urandom), pick_mask());
      else if (pick < 92) push_bare(CMD_RESET);
      else push_bare(CMD_SPARE);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) pat_mem[i] = '0;
    for (int c = 0; c < OUT_CH; c++) cv_held[c] = '0;
    for (int i = 0; i < NOTE_BITS; i++) sub_list[i] = 0;
    play_pos = 0;
    tick_left = 1;
    sub_pos = 0;
    sub_cnt = 0;
    mode_reg = PLAY_ARPEGGIO;
    div_reg = 1;
    sel_reg = 0;
    len_reg = 16;
    rep_reg = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);

    // Reset defaults: empty note list, extreme masks, restart, spare command
    push_bare(CMD_TICK);
    push_item(CMD_WRITE, 3'd0, 4'd0, 12'h001);
    push_item(CMD_WRITE, 3'd0, 4'd1, 12'hfff);
    push_item(CMD_WRITE, 3'd7, 4'd15, 12'h800);
    push_item(CMD_WRITE, 3'd0, 4'd2, 12'h000);
    push_bare(CMD_RESET);
    repeat (3) push_bare(CMD_TICK);
    push_item(CMD_SPARE, '1, '1, '1);
    drain();

    // Poly with a divide of two and a short pattern
    apply_settings(PLAY_CHORD, 5'd2, 3'd0, 5'd3, 5'd1, 1'b0);
    push_bare(CMD_RESET);
    repeat (5) push_bare(CMD_TICK);
    drain();

    // Drum on the top pattern, zero registers acting as one
    apply_settings(PLAY_PERCUSSION, 5'd0, 3'd7, 5'd0, 5'd0, 1'b0);
    push_item(CMD_WRITE, 3'd7, 4'd0, 12'h00f);
    push_bare(CMD_RESET);
    repeat (2) push_bare(CMD_TICK);
    drain();

    // Unused play mode with oversized registers, then arpeggio sub-steps
    apply_settings(PLAY_SPARE, 5'd31, 3'd0, 5'd31, 5'd31, 1'b1);
    push_bare(CMD_RESET);
    repeat (2) push_bare(CMD_TICK);
    drain();
    apply_settings(PLAY_ARPEGGIO, 5'd1, 3'd0, 5'd2, 5'd3, 1'b0);
    repeat (4) push_bare(CMD_TICK);
    drain();

    // Random phases until about the planned number of items has gone through
    while (items_pushed < 450 && phases < 60) begin
      run_random_phase();
    end

    $display("Covered %0d items over %0d register settings (%0d register writes),",
             items_taken, phases, cfg_writes);
    $display("checking %0d fired steps in arpeggio, poly, drum and unused modes.",
             results_checked);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> pattern_step_sequencer_unit.f
src/pss_pkg.sv
src/pss_ram.sv
src/pss_scan.sv
src/pattern_step_sequencer_unit.sv
tb/pattern_step_sequencer_unit_test.sv
